@@ design/spc_pkg.sv @@
// Shared types, codes and helper functions of the site polymorphism classifier.
package spc_pkg;

	localparam int CNT_W = 16;
	localparam int BASE_W = 8;
	localparam int KIND_W = 2;

	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [BASE_W-1:0] base_t;
	typedef logic [KIND_W-1:0] kind_t;

	// Item kinds.
	localparam kind_t K_BASE_A = 2'd0;
	localparam kind_t K_BASE_B = 2'd1;
	localparam kind_t K_OUTGRP = 2'd2;
	localparam kind_t K_END    = 2'd3;

	// Allele tracker occupancy codes.
	localparam logic [1:0] AL_NONE  = 2'd0;
	localparam logic [1:0] AL_ONE   = 2'd1;
	localparam logic [1:0] AL_TWO   = 2'd2;
	localparam logic [1:0] AL_MULTI = 2'd3;

	// Only the first SITE_CAP closed sites enter the flag sequence.
	localparam longint unsigned MAX_SITES = 65535;
	localparam cnt_t SITE_CAP = (MAX_SITES < 65535) ? cnt_t'(MAX_SITES) : '1;

	localparam cnt_t MIN_RUN_SITES = 16'd5;

	// Site counter indexes.
	localparam int NUM_CNT = 10;
	localparam int C_BIAL  = 0;
	localparam int C_MULTI = 1;
	localparam int C_SFA   = 2;
	localparam int C_SFB   = 3;
	localparam int C_SFOUT = 4;
	localparam int C_SXA   = 5;
	localparam int C_SXB   = 6;
	localparam int C_SXAFB = 7;
	localparam int C_SXBFA = 8;
	localparam int C_SS    = 9;

	typedef logic [NUM_CNT-1:0] bump_t;

	typedef struct packed {
		logic [1:0] cnt;
		base_t      first;
		base_t      second;
	} grp_t;

	typedef struct packed {
		logic close;
		logic finish;
	} tally_ctl_t;

	typedef struct packed {
		cnt_t two_allele_sites;
		cnt_t multi_sites;
		cnt_t fixed_outgroup;
		cnt_t fixed_in_a;
		cnt_t fixed_in_b;
		cnt_t private_a;
		cnt_t private_b;
		cnt_t ancestral_private_a;
		cnt_t ancestral_private_b;
		cnt_t shared_sites;
		cnt_t run_count;
		logic runs_valid;
	} res_t;

	function automatic cnt_t sat_inc(cnt_t x);
		return (x == '1) ? x : x + 1'b1;
	endfunction

	function automatic cnt_t sat_add(cnt_t x, cnt_t y);
		logic [CNT_W:0] s;
		s = {1'b0, x} + {1'b0, y};
		return s[CNT_W] ? '1 : s[CNT_W-1:0];
	endfunction

endpackage

@@ design/spc_if.sv @@
// Handshake interfaces for the base stream and the per-locus results.
interface spc_in_if import spc_pkg::*; ();
	logic  valid;
	logic  ready;
	kind_t kind;
	base_t base;
	cnt_t  total_sites;

	modport source (output valid, output kind, output base, output total_sites, input ready);
	modport sink (input valid, input kind, input base, input total_sites, output ready);
endinterface

interface spc_out_if import spc_pkg::*; ();
	logic valid;
	logic ready;
	cnt_t two_allele_sites;
	cnt_t multi_sites;
	cnt_t fixed_outgroup;
	cnt_t fixed_in_a;
	cnt_t fixed_in_b;
	cnt_t private_a;
	cnt_t private_b;
	cnt_t ancestral_private_a;
	cnt_t ancestral_private_b;
	cnt_t shared_sites;
	cnt_t run_count;
	logic runs_valid;

	modport source (output valid, output two_allele_sites, output multi_sites,
		output fixed_outgroup, output fixed_in_a, output fixed_in_b, output private_a,
		output private_b, output ancestral_private_a, output ancestral_private_b,
		output shared_sites, output run_count, output runs_valid, input ready);
	modport sink (input valid, input two_allele_sites, input multi_sites,
		input fixed_outgroup, input fixed_in_a, input fixed_in_b, input private_a,
		input private_b, input ancestral_private_a, input ancestral_private_b,
		input shared_sites, input run_count, input runs_valid, output ready);
endinterface

@@ design/spc_allele.sv @@
// Allele tracker for one group: up to two distinct bases, then multiallelic.
module spc_allele import spc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  add,
	input  logic  clear,
	input  base_t base,
	output grp_t  grp
);

	grp_t grp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_q <= '0;
		end else if (clear) begin
			grp_q <= '0;
		end else if (add) begin
			unique case (grp_q.cnt)
				AL_NONE: begin
					grp_q.first <= base;
					grp_q.cnt   <= AL_ONE;
				end
				AL_ONE: begin
					if (base != grp_q.first) begin
						grp_q.second <= base;
						grp_q.cnt    <= AL_TWO;
					end
				end
				AL_TWO: begin
					if (base != grp_q.first && base != grp_q.second)
						grp_q.cnt <= AL_MULTI;
				end
				default: ;
			endcase
		end
	end

	assign grp = grp_q;

endmodule

@@ design/spc_classify.sv @@
// Site classification from both groups' alleles and the outgroup base.
module spc_classify import spc_pkg::*; (
	input  grp_t  grp_a,
	input  grp_t  grp_b,
	input  base_t outgrp,
	output bump_t bump,
	output logic  flag
);

	base_t a1, a2, b1, b2, o;

	assign a1 = grp_a.first;
	assign a2 = grp_a.second;
	assign b1 = grp_b.first;
	assign b2 = grp_b.second;
	assign o  = outgrp;

	always_comb begin
		bump = '0;
		flag = 1'b0;
		priority if (grp_a.cnt == AL_NONE || grp_b.cnt == AL_NONE ||
				grp_a.cnt == AL_MULTI || grp_b.cnt == AL_MULTI) begin
			bump[C_MULTI] = 1'b1;
		end else if (grp_a.cnt == AL_ONE && grp_b.cnt == AL_ONE) begin
			// Both groups monomorphic: identical, fixed with outgroup, or fixed derived.
			priority if (a1 == b1 && a1 == o) begin
				bump = '0;
			end else if (a1 != b1 && a1 != o && b1 != o) begin
				bump[C_MULTI] = 1'b1;
			end else begin
				bump[C_BIAL] = 1'b1;
				if (a1 == b1) begin
					bump[C_SFOUT] = 1'b1;
				end else begin
					if (a1 == o)
						bump[C_SFB] = 1'b1;
					else
						bump[C_SFA] = 1'b1;
					flag = 1'b1;
				end
			end
		end else if (grp_a.cnt == AL_TWO && grp_b.cnt == AL_ONE) begin
			if ((b1 == a1 || b1 == a2) && (o == b1 || o == a1 || o == a2)) begin
				bump[C_BIAL] = 1'b1;
				if (o == b1)
					bump[C_SXA] = 1'b1;
				else
					bump[C_SXAFB] = 1'b1;
			end else begin
				bump[C_MULTI] = 1'b1;
			end
		end else if (grp_a.cnt == AL_ONE && grp_b.cnt == AL_TWO) begin
			if ((a1 == b1 || a1 == b2) && (o == a1 || o == b1 || o == b2)) begin
				bump[C_BIAL] = 1'b1;
				if (o == a1)
					bump[C_SXB] = 1'b1;
				else
					bump[C_SXBFA] = 1'b1;
			end else begin
				bump[C_MULTI] = 1'b1;
			end
		end else begin
			if (((a1 == b1 && a2 == b2) || (a1 == b2 && a2 == b1)) && (o == a1 || o == a2)) begin
				bump[C_SS]   = 1'b1;
				bump[C_BIAL] = 1'b1;
			end else begin
				bump[C_MULTI] = 1'b1;
			end
		end
	end

endmodule

@@ design/spc_tally.sv @@
// Site counters, derived-fixed flag runs, and the end-of-locus result.
module spc_tally import spc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  tally_ctl_t ctl,
	input  bump_t      bump,
	input  logic       flag,
	input  cnt_t       total_sites,
	input  logic       outgroup_mode,
	output res_t       res
);

	cnt_t cnt_q [NUM_CNT];
	cnt_t runs_q;
	cnt_t ones_q;
	cnt_t seen_q;
	logic last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CNT; i++)
				cnt_q[i] <= '0;
			runs_q <= '0;
			ones_q <= '0;
			seen_q <= '0;
			last_q <= 1'b0;
		end else if (ctl.finish) begin
			for (int i = 0; i < NUM_CNT; i++)
				cnt_q[i] <= '0;
			runs_q <= '0;
			ones_q <= '0;
			seen_q <= '0;
			last_q <= 1'b0;
		end else if (ctl.close) begin
			for (int i = 0; i < NUM_CNT; i++)
				if (bump[i])
					cnt_q[i] <= sat_inc(cnt_q[i]);
			// Sites past the cap are still counted but leave the flag sequence alone.
			if (seen_q < SITE_CAP) begin
				if (seen_q == '0)
					runs_q <= 16'd1;
				else if (flag != last_q)
					runs_q <= sat_inc(runs_q);
				if (flag)
					ones_q <= sat_inc(ones_q);
				last_q <= flag;
				seen_q <= seen_q + 1'b1;
			end
		end
	end

	cnt_t total_cap;
	cnt_t n_sites;
	cnt_t runs;
	cnt_t zeros;
	logic valid;

	always_comb begin
		total_cap = (total_sites > SITE_CAP) ? SITE_CAP : total_sites;
		n_sites   = seen_q;
		runs      = runs_q;
		// Trailing sites not seen are padded as zero flags.
		if (total_cap > seen_q) begin
			if (seen_q == '0)
				runs = 16'd1;
			else if (last_q)
				runs = sat_inc(runs_q);
			n_sites = total_cap;
		end
		if (n_sites == '0)
			runs = 16'd1;
		zeros = (n_sites > ones_q) ? n_sites - ones_q : '0;
		valid = (zeros >= MIN_RUN_SITES) && (ones_q >= MIN_RUN_SITES);
	end

	always_comb begin
		res.two_allele_sites    = cnt_q[C_BIAL];
		res.multi_sites         = cnt_q[C_MULTI];
		res.fixed_outgroup      = outgroup_mode ? sat_add(cnt_q[C_SFA], cnt_q[C_SFB])
		                                        : cnt_q[C_SFOUT];
		res.fixed_in_a          = cnt_q[C_SFA];
		res.fixed_in_b          = cnt_q[C_SFB];
		res.private_a           = outgroup_mode ? sat_add(cnt_q[C_SXA], cnt_q[C_SXAFB])
		                                        : cnt_q[C_SXA];
		res.private_b           = outgroup_mode ? sat_add(cnt_q[C_SXB], cnt_q[C_SXBFA])
		                                        : cnt_q[C_SXB];
		res.ancestral_private_a = cnt_q[C_SXAFB];
		res.ancestral_private_b = cnt_q[C_SXBFA];
		res.shared_sites        = cnt_q[C_SS];
		res.run_count           = valid ? runs : '0;
		res.runs_valid          = valid;
	end

endmodule

@@ design/site_polymorphism_classifier.sv @@
// Each accepted item lands in an input register and is processed from there;
// the block takes one item per cycle, with no bubbles while nothing stalls. Base
// items update the group allele trackers, an outgroup item classifies the site
// and bumps the counters, and an end-of-locus item loads the output register
// with all counts and clears the locus state; the result is presented from the
// output register once loaded. The output register is the only place the input
// side can stall: an end-of-locus item waits in the input register while a
// previous result has not yet been taken. Counters saturate at 65535.
module site_polymorphism_classifier import spc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	spc_in_if.sink   sample,
	spc_out_if.source result,
	input  logic     cfg_we,
	input  logic     cfg_wdata
);

	logic  mode_q;
	logic  valid_s1;
	kind_t kind_s1;
	base_t base_s1;
	cnt_t  total_s1;
	logic  go_s1;
	logic  res_valid_q;
	res_t  res_q;

	grp_t       grp_a, grp_b;
	bump_t      bump;
	logic       flag;
	tally_ctl_t ctl;
	res_t       res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mode_q <= 1'b0;
		else if (cfg_we)
			mode_q <= cfg_wdata;
	end

	assign go_s1 = valid_s1 && (kind_s1 != K_END || !res_valid_q || result.ready);
	assign sample.ready = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (sample.valid && sample.ready)
			valid_s1 <= 1'b1;
		else if (go_s1)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			kind_s1  <= sample.kind;
			base_s1  <= sample.base;
			total_s1 <= sample.total_sites;
		end
	end

	assign ctl.close  = go_s1 && kind_s1 == K_OUTGRP;
	assign ctl.finish = go_s1 && kind_s1 == K_END;

	spc_allele u_allele_a (
		.clk   (clk),
		.arst_n(arst_n),
		.add   (go_s1 && kind_s1 == K_BASE_A),
		.clear (ctl.close || ctl.finish),
		.base  (base_s1),
		.grp   (grp_a)
	);

	spc_allele u_allele_b (
		.clk   (clk),
		.arst_n(arst_n),
		.add   (go_s1 && kind_s1 == K_BASE_B),
		.clear (ctl.close || ctl.finish),
		.base  (base_s1),
		.grp   (grp_b)
	);

	spc_classify u_classify (
		.grp_a (grp_a),
		.grp_b (grp_b),
		.outgrp(base_s1),
		.bump  (bump),
		.flag  (flag)
	);

	spc_tally u_tally (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.bump         (bump),
		.flag         (flag),
		.total_sites  (total_s1),
		.outgroup_mode(mode_q),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (ctl.finish)
			res_valid_q <= 1'b1;
		else if (result.ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctl.finish)
			res_q <= res;
	end

	assign result.valid               = res_valid_q;
	assign result.two_allele_sites    = res_q.two_allele_sites;
	assign result.multi_sites         = res_q.multi_sites;
	assign result.fixed_outgroup      = res_q.fixed_outgroup;
	assign result.fixed_in_a          = res_q.fixed_in_a;
	assign result.fixed_in_b          = res_q.fixed_in_b;
	assign result.private_a           = res_q.private_a;
	assign result.private_b           = res_q.private_b;
	assign result.ancestral_private_a = res_q.ancestral_private_a;
	assign result.ancestral_private_b = res_q.ancestral_private_b;
	assign result.shared_sites        = res_q.shared_sites;
	assign result.run_count           = res_q.run_count;
	assign result.runs_valid          = res_q.runs_valid;

`ifndef SYNTH
	// A result only appears after an end-of-locus item left the input register.
	a_result_from_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(valid_s1 && kind_s1 == K_END))
		else $error("result raised without an end-of-locus item");

	// The input side stalls only behind an end item blocked by a pending result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!sample.ready |-> (valid_s1 && kind_s1 == K_END && res_valid_q && !result.ready))
		else $error("input stalled without a pending result");

	// An invalid runs statistic always reports a zero run count.
	a_runs_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_q.runs_valid) |-> (res_q.run_count == '0))
		else $error("run count nonzero while runs statistic invalid");

	// An unaccepted result must not be overwritten by a new one.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !result.ready) |-> !ctl.finish)
		else $error("pending result overwritten");
`endif

endmodule
